@@ src/slom_pkg.sv @@
// Package for the skip-list ordered map: command and status codes, sequencer states.
// Used by skip_list_ordered_map and its bench; depends on nothing.
package slom_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_SEARCH = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_REMOVED   = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_KEY,
        S_WALK_CMP,
        S_HIT_CHK,
        S_INS_RD,
        S_INS_WR,
        S_INS_LINK,
        S_REM_RD,
        S_REM_CHK,
        S_REM_WR,
        S_TOP_CHK,
        S_DONE
    } state_t;

endpackage

@@ src/skip_list_ordered_map.sv @@
// Skip-list ordered map over a fixed node pool with an iterative link walker.
// Depends on slom_pkg.
//
// One item is handled at a time; in_ready stays low from acceptance until the result has
// been taken. After reset the block fills its free-slot stack (CAPACITY slots, 64 by
// default) before in_ready first rises. A walk starts at the header on the level in
// use and, for each rightward hop and each level visited, reads a link, reads a key and
// compares, all through one link memory port, one key memory port and a single shared
// signed comparator. An insert then links levels 0 to its height, one level at a time
// (link read, new node write, predecessor write). A remove unlinks levels upward from 0
// until the predecessor no longer points at the node or the level in use is done, then
// checks the top level and drops empty levels. The result is held in an output register
// until taken.
module skip_list_ordered_map #(
    parameter int LEVEL_LIMIT = 6,
    parameter int CAPACITY    = 64,
    parameter int KEY_BITS    = 32,
    parameter int VALUE_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic signed [31:0] lookup_key,
    input  logic [31:0] entry_value,
    input  logic [3:0]  insert_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [31:0] found_value,
    output logic [7:0]  compare_count,
    output logic [6:0]  entries_held,
    output logic [3:0]  levels_in_use
);
    import slom_pkg::*;

    localparam int LEVELS = LEVEL_LIMIT + 1;
    localparam int PW     = $clog2(CAPACITY + 1);   // link incl. null / head
    localparam int SW     = $clog2(CAPACITY);
    localparam int LW     = $clog2(LEVELS);
    localparam int AW     = $clog2(CAPACITY * LEVELS);
    localparam logic [PW-1:0] NIL = PW'(CAPACITY);

    // node storage
    logic [KEY_BITS-1:0]   key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];
    logic [PW-1:0]         link_mem [CAPACITY*LEVELS];
    logic [SW-1:0]         free_mem [CAPACITY];

    logic [PW-1:0] head_reg [LEVELS];
    logic [PW-1:0] upd_reg  [LEVELS];
    logic [PW:0]   free_total_reg, free_total_next;
    logic [PW:0]   entry_reg, entry_next;
    logic [3:0]    top_reg, top_next;
    logic          free_init_reg;
    logic [SW-1:0] free_init_cnt_reg;

    state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [LW-1:0]         hgt_reg;
    logic [PW-1:0]         cur_reg, cur_next;
    logic [PW-1:0]         nx_reg, nx_next;
    logic [PW-1:0]         hit_reg, hit_next;
    logic [LW-1:0]         lvl_reg, lvl_next;
    logic [7:0]            hops_reg, hops_next;
    logic [SW-1:0]         slot_reg, slot_next;

    // memory ports
    logic                  link_we;
    logic [AW-1:0]         link_waddr, link_raddr;
    logic [PW-1:0]         link_wdata, link_rdata_reg;
    logic [SW-1:0]         key_raddr;
    logic [KEY_BITS-1:0]   key_rdata_reg;
    logic [VALUE_BITS-1:0] val_rdata_reg;
    logic [SW-1:0]         free_rdata_reg;
    logic                  kv_we, free_push;
    logic                  upd_clr, upd_we;

    // head link writes
    logic          head_we;
    logic [PW-1:0] head_wdata;

    status_t     res_status_reg, res_status_next;
    logic [31:0] res_value_reg, res_value_next;
    logic [7:0]  res_count_reg, res_count_next;
    logic        out_valid_reg, out_valid_next;

    logic [KEY_BITS-1:0] key_ext;
    logic                key_lt, key_eq, hit_ok;
    logic [PW-1:0]       cur_link, pred_link;

    assign key_ext = KEY_BITS'(lookup_key);

    function automatic logic [AW-1:0] laddr(input logic [SW-1:0] n, input logic [LW-1:0] l);
        return AW'(n) * AW'(LEVELS) + AW'(l);
    endfunction

    // shared comparator: stored key less than lookup key, signed
    assign key_lt = $signed(key_rdata_reg) < $signed(key_reg);
    assign key_eq = key_rdata_reg == key_reg;
    assign hit_ok = (hit_reg != NIL) && key_eq;

    // link of cur or of the level predecessor, after read latency
    assign cur_link  = (cur_reg == NIL) ? head_reg[lvl_reg] : link_rdata_reg;
    assign pred_link = (upd_reg[lvl_reg] == NIL) ? head_reg[lvl_reg] : link_rdata_reg;

    assign in_ready      = (state_reg == S_IDLE) && free_init_reg && !out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign status        = res_status_reg;
    assign found_value   = res_value_reg;
    assign compare_count = res_count_reg;
    assign entries_held  = 7'(entry_reg);
    assign levels_in_use = top_reg;

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        nx_next         = nx_reg;
        lvl_next        = lvl_reg;
        hops_next       = hops_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        top_next        = top_reg;
        free_total_next = free_total_reg;
        entry_next      = entry_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg;
        upd_clr    = 1'b0;
        upd_we     = 1'b0;
        kv_we      = 1'b0;
        free_push  = 1'b0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = laddr(cur_reg[SW-1:0], lvl_reg);
        key_raddr  = nx_reg[SW-1:0];
        head_we    = 1'b0;
        head_wdata = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cur_next   = NIL;
                    lvl_next   = LW'(top_reg);
                    hops_next  = '0;
                    upd_clr    = 1'b1;
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:  state_next = S_WALK_KEY;   // link read in flight
            S_WALK_KEY:
            begin
                nx_next    = cur_link;
                key_raddr  = cur_link[SW-1:0];
                state_next = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                // key of nx landed this cycle; key_raddr stays on nx for the hit check
                if (nx_reg != NIL && key_lt)
                begin
                    cur_next   = nx_reg;
                    hops_next  = (hops_reg == 8'hFF) ? hops_reg : hops_reg + 8'd1;
                    state_next = S_WALK_RD;
                end
                else
                begin
                    upd_we = 1'b1;
                    if (lvl_reg == '0)
                    begin
                        hit_next   = nx_reg;
                        state_next = S_HIT_CHK;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg - 1'b1;
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_HIT_CHK:
            begin
                res_status_next = ST_NOT_FOUND;
                res_value_next  = '0;
                res_count_next  = '0;
                lvl_next        = '0;
                state_next      = S_DONE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (hit_ok)
                            res_status_next = ST_DUPLICATE;
                        else if (free_total_reg == '0)
                            res_status_next = ST_FULL;
                        else
                        begin
                            res_status_next = ST_INSERTED;
                            slot_next       = free_rdata_reg;
                            free_total_next = free_total_reg - 1'b1;
                            entry_next      = entry_reg + 1'b1;
                            if (4'(hgt_reg) > top_reg)
                                top_next = 4'(hgt_reg);
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        if (hit_ok)
                        begin
                            res_status_next = ST_FOUND;
                            res_value_next  = 32'(val_rdata_reg);
                            res_count_next  = (hops_reg == 8'hFF) ? hops_reg : hops_reg + 8'd1;
                        end
                        else
                            res_count_next = hops_reg;
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_ok)
                        begin
                            res_status_next = ST_REMOVED;
                            free_push       = 1'b1;
                            free_total_next = free_total_reg + 1'b1;
                            entry_next      = entry_reg - 1'b1;
                            state_next      = S_REM_RD;
                        end
                    end
                    default: ;
                endcase
            end
            S_INS_RD:
            begin
                link_raddr = laddr(upd_reg[lvl_reg][SW-1:0], lvl_reg);
                kv_we      = (lvl_reg == '0);
                state_next = S_INS_WR;
            end
            S_INS_WR:
            begin
                // new node takes over the predecessor's link
                link_we    = 1'b1;
                link_waddr = laddr(slot_reg, lvl_reg);
                link_wdata = pred_link;
                state_next = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                if (upd_reg[lvl_reg] == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = PW'(slot_reg);
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = laddr(upd_reg[lvl_reg][SW-1:0], lvl_reg);
                    link_wdata = PW'(slot_reg);
                end
                if (lvl_reg == hgt_reg)
                    state_next = S_DONE;
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_INS_RD;
                end
            end
            S_REM_RD:
            begin
                link_raddr = laddr(upd_reg[lvl_reg][SW-1:0], lvl_reg);
                state_next = S_REM_CHK;
            end
            S_REM_CHK:
            begin
                // stop at the first level where the predecessor does not point at hit
                if (pred_link != hit_reg)
                    state_next = S_TOP_CHK;
                else
                begin
                    link_raddr = laddr(hit_reg[SW-1:0], lvl_reg);
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                if (upd_reg[lvl_reg] == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = link_rdata_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = laddr(upd_reg[lvl_reg][SW-1:0], lvl_reg);
                    link_wdata = link_rdata_reg;
                end
                if (4'(lvl_reg) == top_reg)
                    state_next = S_TOP_CHK;
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_REM_RD;
                end
            end
            S_TOP_CHK:
            begin
                // drop empty levels from the top
                if (top_reg != 4'd0 && head_reg[top_reg[LW-1:0]] == NIL)
                    top_next = top_reg - 4'd1;
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            free_total_reg    <= (PW+1)'(CAPACITY);
            top_reg           <= '0;
            entry_reg         <= '0;
            free_init_reg     <= 1'b0;
            free_init_cnt_reg <= '0;
            cur_reg           <= NIL;
            nx_reg            <= NIL;
            hit_reg           <= NIL;
            lvl_reg           <= '0;
            hops_reg          <= '0;
            slot_reg          <= '0;
            res_status_reg    <= ST_NOT_FOUND;
            res_value_reg     <= '0;
            res_count_reg     <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                upd_reg[i]  <= NIL;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            free_total_reg <= free_total_next;
            top_reg        <= top_next;
            entry_reg      <= entry_next;
            cur_reg        <= cur_next;
            nx_reg         <= nx_next;
            hit_reg        <= hit_next;
            lvl_reg        <= lvl_next;
            hops_reg       <= hops_next;
            slot_reg       <= slot_next;
            res_status_reg <= res_status_next;
            res_value_reg  <= res_value_next;
            res_count_reg  <= res_count_next;
            if (!free_init_reg)
            begin
                if (free_init_cnt_reg == SW'(CAPACITY - 1))
                    free_init_reg <= 1'b1;
                free_init_cnt_reg <= free_init_cnt_reg + 1'b1;
            end
            if (head_we)
                head_reg[lvl_reg] <= head_wdata;
            if (upd_clr)
            begin
                for (int i = 0; i < LEVELS; i++)
                    upd_reg[i] <= NIL;
            end
            else if (upd_we)
                upd_reg[lvl_reg] <= cur_reg;
        end
    end

    // payload registers and memories
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            cmd_reg <= cmd_t'(cmd);
            key_reg <= key_ext;
            val_reg <= VALUE_BITS'(entry_value);
            hgt_reg <= (insert_level > 4'(LEVEL_LIMIT)) ? LW'(LEVEL_LIMIT) : LW'(insert_level);
        end
        link_rdata_reg <= link_mem[link_raddr];
        if (link_we)
            link_mem[link_waddr] <= link_wdata;
        key_rdata_reg  <= key_mem[key_raddr];
        val_rdata_reg  <= val_mem[key_raddr];
        free_rdata_reg <= free_mem[SW'(free_total_reg - 1'b1)];
        if (kv_we)
        begin
            key_mem[slot_reg] <= key_reg;
            val_mem[slot_reg] <= val_reg;
        end
        // fill the free stack after reset: top of stack is slot 0
        if (!free_init_reg)
            free_mem[SW'(CAPACITY - 1) - free_init_cnt_reg] <= free_init_cnt_reg;
        else if (free_push)
            free_mem[SW'(free_total_reg)] <= hit_reg[SW-1:0];
    end

    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");
    ap_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted item while busy");
    ap_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_held <= 7'(CAPACITY))
        else $error("entry count beyond capacity");

endmodule

@@ verif/tb_skip_list_ordered_map.sv @@
// Self-checking bench for skip_list_ordered_map: drives insert/search/remove/no-op items and
// checks every result against an in-bench ordered-map predictor. Depends on slom_pkg.
module tb_skip_list_ordered_map;
    import slom_pkg::*;

    localparam int MAXLV = 6;
    localparam int POOL  = 64;
    localparam int NULLP = POOL;

    typedef struct packed {
        cmd_t        op;
        logic [31:0] key;
        logic [31:0] val;
        logic [3:0]  lvl;
    } map_req_t;

    typedef struct packed {
        status_t     st;
        logic [31:0] val;
        logic [7:0]  cmps;
        logic [6:0]  held;
        logic [3:0]  tops;
    } map_rsp_t;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, in_ready, out_valid, out_ready = 0;
    logic [1:0] cmd = 0;
    logic signed [31:0] lookup_key = 0;
    logic [31:0] entry_value = 0;
    logic [3:0] insert_level = 0;
    logic [2:0] status;
    logic [31:0] found_value;
    logic [7:0] compare_count;
    logic [6:0] entries_held;
    logic [3:0] levels_in_use;

    skip_list_ordered_map dut (.*);

    initial forever #5 clk = ~clk;

    // predictor state
    logic signed [31:0] pk_key [POOL];
    logic [31:0] pk_val [POOL];
    int pk_next [POOL][MAXLV+1];
    int hd_next [MAXLV+1];
    int spare [$];
    int cur_top, cur_count;
    int live_keys [$];

    map_req_t pending_items [$];
    map_rsp_t awaited [$];
    int errors = 0, issued = 0, checked = 0;
    int snd_idle = 0, rcv_idle = 0;
    bit calm = 0, pause_sender = 0;
    int n_ins = 0, n_hit = 0, n_rem = 0, n_full = 0;

    function automatic int link_of(int owner, int l);
        return (owner == NULLP) ? hd_next[l] : pk_next[owner][l];
    endfunction

    function automatic void set_link_of(int owner, int l, int v);
        if (owner == NULLP) hd_next[l] = v;
        else pk_next[owner][l] = v;
    endfunction

    function automatic map_rsp_t map_apply(map_req_t r);
        map_rsp_t o;
        int prev [MAXLV+1];
        int at, nx, hops, hit, slot, h;
        logic signed [31:0] k;
        k = r.key;
        at = NULLP;
        hops = 0;
        for (int l = 0; l <= MAXLV; l++) prev[l] = NULLP;
        for (int l = cur_top; l >= 0; l--)
        begin
            nx = link_of(at, l);
            while (nx != NULLP && pk_key[nx] < k)
            begin
                at = nx;
                hops++;
                nx = link_of(at, l);
            end
            prev[l] = at;
        end
        hit = link_of(at, 0);
        if (hit != NULLP && pk_key[hit] != k) hit = NULLP;
        o = '0;
        o.st = ST_NOT_FOUND;
        case (r.op)
            CMD_INSERT:
                if (hit != NULLP) o.st = ST_DUPLICATE;
                else if (spare.size() == 0) o.st = ST_FULL;
                else
                begin
                    slot = spare.pop_back();
                    h = (r.lvl > MAXLV) ? MAXLV : r.lvl;
                    if (h > cur_top) cur_top = h;
                    pk_key[slot] = k;
                    pk_val[slot] = r.val;
                    for (int l = 0; l <= h; l++)
                    begin
                        pk_next[slot][l] = link_of(prev[l], l);
                        set_link_of(prev[l], l, slot);
                    end
                    cur_count++;
                    live_keys.push_back(k);
                    o.st = ST_INSERTED;
                end
            CMD_SEARCH:
            begin
                if (hit != NULLP)
                begin
                    hops++;
                    o.st = ST_FOUND;
                    o.val = pk_val[hit];
                end
                o.cmps = (hops > 255) ? 8'd255 : hops[7:0];
            end
            CMD_REMOVE:
                if (hit != NULLP)
                begin
                    for (int l = 0; l <= cur_top; l++)
                    begin
                        if (link_of(prev[l], l) != hit) break;
                        set_link_of(prev[l], l, pk_next[hit][l]);
                    end
                    spare.push_back(hit);
                    cur_count--;
                    foreach (live_keys[i])
                        if (live_keys[i] == k)
                        begin
                            live_keys.delete(i);
                            break;
                        end
                    while (cur_top > 0 && hd_next[cur_top] == NULLP) cur_top--;
                    o.st = ST_REMOVED;
                end
            default: ;
        endcase
        o.held = cur_count[6:0];
        o.tops = cur_top[3:0];
        return o;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                awaited.push_back(map_apply(pending_items.pop_front()));
                issued++;
            end
            if (!in_valid || in_ready)
            begin
                if (snd_idle > 0)
                begin
                    snd_idle <= snd_idle - 1;
                    in_valid <= 0;
                end
                else if (pending_items.size() > 0 && !pause_sender
                         && !(!calm && $urandom_range(0, 15) == 0))
                begin
                    in_valid <= 1;
                    cmd <= pending_items[0].op;
                    lookup_key <= pending_items[0].key;
                    entry_value <= pending_items[0].val;
                    insert_level <= pending_items[0].lvl;
                end
                else
                begin
                    in_valid <= 0;
                    if (!calm && $urandom_range(0, 15) == 0) snd_idle <= $urandom_range(1, 18);
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        map_rsp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (awaited.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected result status=%0d", $time, status);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status != want.st)
                    begin
                        errors++;
                        $display("%0t status exp %0d got %0d", $time, want.st, status);
                    end
                    if (found_value != want.val)
                    begin
                        errors++;
                        $display("%0t found_value exp %h got %h", $time, want.val, found_value);
                    end
                    if (compare_count != want.cmps)
                    begin
                        errors++;
                        $display("%0t compare_count exp %0d got %0d", $time, want.cmps,
                                 compare_count);
                    end
                    if (entries_held != want.held)
                    begin
                        errors++;
                        $display("%0t entries_held exp %0d got %0d", $time, want.held,
                                 entries_held);
                    end
                    if (levels_in_use != want.tops)
                    begin
                        errors++;
                        $display("%0t levels_in_use exp %0d got %0d", $time, want.tops,
                                 levels_in_use);
                    end
                    if (want.st == ST_INSERTED) n_ins++;
                    if (want.st == ST_FOUND) n_hit++;
                    if (want.st == ST_REMOVED) n_rem++;
                    if (want.st == ST_FULL) n_full++;
                end
            end
            if (rcv_idle > 0)
            begin
                rcv_idle <= rcv_idle - 1;
                out_ready <= 0;
            end
            else if (!calm && $urandom_range(0, 12) == 0)
            begin
                rcv_idle <= $urandom_range(1, 18);
                out_ready <= 0;
            end
            else out_ready <= 1;
        end
    end

    // pick a key: mostly one in the map or from a small pool, sometimes fully random
    function automatic logic [31:0] pick_key(int bias);
        int r;
        logic [31:0] k;
        r = $urandom_range(0, 99);
        if (r < bias && live_keys.size() > 0)
            k = live_keys[$urandom_range(0, live_keys.size() - 1)];
        else if (r < 85)
            k = $urandom_range(0, 95) - 48;
        else
            k = $urandom;
        return k;
    endfunction

    function automatic void add_item(cmd_t op, logic [31:0] k, logic [31:0] v, logic [3:0] l);
        map_req_t r;
        r.op = op;
        r.key = k;
        r.val = v;
        r.lvl = l;
        pending_items.push_back(r);
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || awaited.size() > 0) @(posedge clk);
    endtask

    initial
    begin
        int pick;
        int base;
        cur_top = 0;
        cur_count = 0;
        for (int l = 0; l <= MAXLV; l++) hd_next[l] = NULLP;
        for (int i = 0; i < POOL; i++) spare.push_back(POOL - 1 - i);
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // directed: edges of key range, all commands, duplicate, missing remove, clamp
        add_item(CMD_SEARCH, 32'h0, 32'h0, 4'd0);
        add_item(CMD_REMOVE, 32'h5, 32'h0, 4'd0);
        add_item(CMD_INSERT, 32'h8000_0000, 32'hFFFF_FFFF, 4'd15);
        add_item(CMD_INSERT, 32'h7FFF_FFFF, 32'h0, 4'd0);
        add_item(CMD_INSERT, 32'h0, 32'hA5A5_5A5A, 4'd6);
        add_item(CMD_INSERT, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 4'd7);
        add_item(CMD_INSERT, 32'h0, 32'h1234, 4'd2);
        add_item(CMD_SEARCH, 32'h8000_0000, 32'h0, 4'd0);
        add_item(CMD_SEARCH, 32'h7FFF_FFFF, 32'h0, 4'd0);
        add_item(CMD_SEARCH, 32'hFFFF_FFFF, 32'h0, 4'd0);
        add_item(CMD_SEARCH, 32'h1, 32'h0, 4'd0);
        add_item(CMD_NONE, 32'h0, 32'hFFFF_FFFF, 4'd3);
        add_item(CMD_REMOVE, 32'h0, 32'h0, 4'd0);
        add_item(CMD_REMOVE, 32'h8000_0000, 32'h0, 4'd0);
        add_item(CMD_REMOVE, 32'h0, 32'h0, 4'd0);
        add_item(CMD_REMOVE, 32'hFFFF_FFFF, 32'h0, 4'd0);
        add_item(CMD_REMOVE, 32'h7FFF_FFFF, 32'h0, 4'd0);
        drain();

        // fill the pool to overflow; partway through hold the sender until all results are in
        base = issued;
        for (int i = 0; i < 66; i++)
            add_item(CMD_INSERT, i * 3 - 100, $urandom, $urandom_range(0, 15));
        while (issued < base + 30) @(posedge clk);
        pause_sender = 1;
        while (awaited.size() > 0 || in_valid) @(posedge clk);
        pause_sender = 0;
        drain();
        for (int i = 0; i < 66; i++)
            add_item(CMD_SEARCH, i * 3 - 100, 0, 0);
        drain();

        // random mix; predictor runs at acceptance so live keys lag only the queue
        for (int i = 0; i < 1000; i++)
        begin
            if (i == 850) calm = 1;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_item(CMD_INSERT, pick_key(20), $urandom, $urandom_range(0, 15));
            else if (pick < 70)
                add_item(CMD_SEARCH, pick_key(70), $urandom, $urandom_range(0, 15));
            else if (pick < 96)
                add_item(CMD_REMOVE, pick_key(70), $urandom, $urandom_range(0, 15));
            else
                add_item(CMD_NONE, pick_key(50), $urandom, $urandom_range(0, 15));
            if (pending_items.size() > 8)
                while (pending_items.size() > 2) @(posedge clk);
        end
        drain();
        repeat (200) @(posedge clk);
        $display("covered %0d items: %0d inserts, %0d hits, %0d removes, %0d full rejects",
                 issued, n_ins, n_hit, n_rem, n_full);
        if (errors == 0 && awaited.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout after %0d results", checked);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
